>>> hw/rtl/hmvc_pkg.sv
package hmvc_pkg;

    localparam int BLOCKS       = 252;
    localparam int BLOCK_VALUES = 27;
    localparam int CLASSES      = 10;
    localparam int COUNT_W      = 16;
    localparam int VOTE_W       = 24;

    localparam int CMD_W     = 2;
    localparam int BLK_W     = 8;
    localparam int VAL_W     = 5;
    localparam int LBL_W     = 4;
    localparam int MODE_W    = 3;
    localparam int CLS_OUT_W = 4;

    localparam int NCH      = 3;
    localparam int CH_W     = 2;
    localparam int ROWS     = BLOCKS * BLOCK_VALUES;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int RAW_W    = 16;
    localparam int CLS_W    = $clog2(CLASSES);
    localparam int FUSE_W   = VOTE_W + 3;
    localparam int PTS_W    = $clog2(3 * (CLASSES - 1) + 1);
    localparam int SUM_W    = ((COUNT_W > VOTE_W) ? COUNT_W : VOTE_W) + 1;
    localparam int LEAD10_W = VOTE_W + 4;

    localparam logic [VAL_W-1:0] PIXEL_BG = 5'd0;
    localparam logic [VAL_W-1:0] GRAD_BG  = 5'd13;

    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRAIN    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd2;

    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MAJ    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BORDA  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_VGRAD  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PV     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_WEIGHT = 3'd5;

    typedef logic [CLASSES-1:0][COUNT_W-1:0] t_row;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [BLK_W-1:0] block_index;
        logic [VAL_W-1:0] pixel_value;
        logic [VAL_W-1:0] hgrad_value;
        logic [VAL_W-1:0] vgrad_value;
        logic [LBL_W-1:0] class_label;
        logic             last_block;
    } t_item;

    typedef struct packed {
        logic accept;
        logic update;
        logic clr_step;
        logic scan_step;
        logic pscan_step;
        logic bload;
        logic bcmp;
        logic bfin;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_clear;
        logic is_result;
        logic clr_last;
        logic scan_last;
        logic borda;
        logic cmp_last;
        logic pass_last;
        logic ch_last;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hw/rtl/hmvc_ifs.sv
interface hmvc_in_if import hmvc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [BLK_W-1:0] block_index;
    logic [VAL_W-1:0] pixel_value;
    logic [VAL_W-1:0] hgrad_value;
    logic [VAL_W-1:0] vgrad_value;
    logic [LBL_W-1:0] class_label;
    logic             last_block;

    modport source (
        output valid, command, block_index, pixel_value, hgrad_value, vgrad_value,
        output class_label, last_block,
        input  ready
    );
    modport sink (
        input  valid, command, block_index, pixel_value, hgrad_value, vgrad_value,
        input  class_label, last_block,
        output ready
    );
endinterface

interface hmvc_out_if import hmvc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CLS_OUT_W-1:0] fused_class;
    logic [CLS_OUT_W-1:0] pixel_class;
    logic [CLS_OUT_W-1:0] hgrad_class;
    logic [CLS_OUT_W-1:0] vgrad_class;

    modport source (
        output valid, fused_class, pixel_class, hgrad_class, vgrad_class,
        input  ready
    );
    modport sink (
        input  valid, fused_class, pixel_class, hgrad_class, vgrad_class,
        output ready
    );
endinterface

interface hmvc_cfg_if import hmvc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] fusion_mode;

    modport source (output valid, fusion_mode, input ready);
    modport sink (input valid, fusion_mode, output ready);
endinterface

>>> hw/rtl/hmvc_ctrl.sv
module hmvc_ctrl import hmvc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_UPDATE = 9'b000000100,
        S_SCAN   = 9'b000001000,
        S_BLOAD  = 9'b000010000,
        S_BCMP   = 9'b000100000,
        S_BFIN   = 9'b001000000,
        S_PSCAN  = 9'b010000000,
        S_RESULT = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                if (i_stat.is_clear) begin
                    n_state = S_CLEAR;
                end else if (i_stat.is_result) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = i_stat.borda ? S_BLOAD : S_RESULT;
                end
            end
            S_BLOAD: begin
                o_cmd.bload = 1'b1;
                n_state     = S_BCMP;
            end
            S_BCMP: begin
                o_cmd.bcmp = 1'b1;
                if (i_stat.cmp_last) begin
                    n_state = S_BFIN;
                end
            end
            S_BFIN: begin
                o_cmd.bfin = 1'b1;
                if (i_stat.pass_last && i_stat.ch_last) begin
                    n_state = S_PSCAN;
                end else begin
                    n_state = S_BLOAD;
                end
            end
            S_PSCAN: begin
                o_cmd.pscan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

>>> hw/rtl/hmvc_dp.sv
module hmvc_dp import hmvc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_item             i_item,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    hmvc_cfg_if.sink          i_cfg,
    hmvc_out_if.source        o_out
);

    localparam logic [SUM_W-1:0] VOTE_LIM = SUM_W'((64'd1 << VOTE_W) - 64'd1);

    function automatic logic [ROW_W-1:0] row_of(input logic [BLK_W-1:0] blk,
                                                input logic [VAL_W-1:0] val);
        logic [RAW_W-1:0] raw;
        raw = RAW_W'(blk) * RAW_W'(BLOCK_VALUES) + RAW_W'(val);
        return raw[ROW_W-1:0];
    endfunction

    function automatic logic val_ok(input logic [VAL_W-1:0] val);
        return val < VAL_W'(BLOCK_VALUES);
    endfunction

    function automatic logic [VOTE_W-1:0] sat_add(input logic [VOTE_W-1:0] v,
                                                  input logic [COUNT_W-1:0] c);
        logic [SUM_W-1:0] s;
        s = SUM_W'(v) + SUM_W'(c);
        return (s > VOTE_LIM) ? VOTE_LIM[VOTE_W-1:0] : s[VOTE_W-1:0];
    endfunction

    function automatic logic [FUSE_W-1:0] fuse_sum(input logic [MODE_W-1:0] mode,
                                                   input logic [VOTE_W-1:0] p,
                                                   input logic [VOTE_W-1:0] h,
                                                   input logic [VOTE_W-1:0] v);
        logic [FUSE_W-1:0] fp;
        logic [FUSE_W-1:0] fh;
        logic [FUSE_W-1:0] fv;
        fp = FUSE_W'(p);
        fh = FUSE_W'(h);
        fv = FUSE_W'(v);
        case (mode)
            MODE_VGRAD:  return (fv << 1) + fp;
            MODE_PV:     return fp + fv;
            MODE_WEIGHT: return (fp << 1) + fh + (fv << 2);
            default:     return fp + fh + fv;
        endcase
    endfunction

    t_item                r_item;
    logic [MODE_W-1:0]    r_mode;
    logic [ROW_W-1:0]     r_clr_ptr;
    logic [VAL_W-1:0]     in_vals   [NCH];
    logic [VAL_W-1:0]     item_vals [NCH];
    logic [VAL_W-1:0]     bg_vals   [NCH];
    logic                 blk_ok;
    logic                 lbl_ok;
    logic                 ch_train  [NCH];
    logic                 ch_vote   [NCH];
    t_row                 rd_row    [NCH];
    logic [VOTE_W-1:0]    r_votes   [NCH][CLASSES];

    logic [CLS_W-1:0]     r_c;
    logic [VOTE_W-1:0]    sv        [NCH];
    logic [VOTE_W-1:0]    r_first   [NCH];
    logic [VOTE_W-1:0]    r_second  [NCH];
    logic [CLS_W-1:0]     r_top     [NCH];
    logic [VOTE_W-1:0]    n_first   [NCH];
    logic [VOTE_W-1:0]    n_second  [NCH];
    logic [CLS_W-1:0]     n_top     [NCH];
    logic [FUSE_W-1:0]    fsum;
    logic [FUSE_W-1:0]    r_best;
    logic [CLS_W-1:0]     r_best_idx;

    logic [CLS_W-1:0]     r_ord     [CLASSES];
    logic [PTS_W-1:0]     r_points  [CLASSES];
    logic [CLS_W-1:0]     r_bi;
    logic [CLS_W-1:0]     r_bj;
    logic [CH_W-1:0]      r_bch;
    logic [CLS_W-1:0]     r_champ;
    logic [VOTE_W-1:0]    r_champ_val;
    logic [VOTE_W-1:0]    bval;
    logic [PTS_W-1:0]     r_pbest;
    logic [CLS_W-1:0]     r_pidx;

    logic [VOTE_W-1:0]    lead      [NCH];
    logic [VOTE_W-1:0]    peak;
    logic [LEAD10_W-1:0]  lead10;
    logic [CLS_W-1:0]     fused;

    logic                 r_valid;
    logic [CLS_OUT_W-1:0] r_fused;
    logic [CLS_OUT_W-1:0] r_pcls;
    logic [CLS_OUT_W-1:0] r_hcls;
    logic [CLS_OUT_W-1:0] r_vcls;

    assign in_vals[0]   = i_item.pixel_value;
    assign in_vals[1]   = i_item.hgrad_value;
    assign in_vals[2]   = i_item.vgrad_value;
    assign item_vals[0] = r_item.pixel_value;
    assign item_vals[1] = r_item.hgrad_value;
    assign item_vals[2] = r_item.vgrad_value;
    assign bg_vals[0]   = PIXEL_BG;
    assign bg_vals[1]   = GRAD_BG;
    assign bg_vals[2]   = GRAD_BG;

    assign blk_ok = int'(r_item.block_index) < BLOCKS;
    assign lbl_ok = int'(r_item.class_label) < CLASSES;

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            ch_train[ch] = (r_item.command == CMD_TRAIN) && blk_ok && lbl_ok
                           && val_ok(item_vals[ch]);
            ch_vote[ch]  = (r_item.command == CMD_CLASSIFY) && blk_ok
                           && val_ok(item_vals[ch]) && (item_vals[ch] != bg_vals[ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_item;
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ADD;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.fusion_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_ptr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_ptr <= o_stat.clr_last ? '0 : r_clr_ptr + 1'b1;
        end
    end

    for (genvar g = 0; g < NCH; g++) begin : g_chan
        t_row             mem [ROWS];
        t_row             r_rd;
        t_row             wr_data;
        logic             we;
        logic [ROW_W-1:0] wa;
        logic [CLS_W-1:0] lane;

        assign lane = r_item.class_label[CLS_W-1:0];
        assign we   = i_cmd.clr_step || (i_cmd.update && ch_train[g]);
        assign wa   = i_cmd.clr_step ? r_clr_ptr
                                     : row_of(r_item.block_index, item_vals[g]);

        always_comb begin
            wr_data = r_rd;
            if (i_cmd.clr_step) begin
                wr_data = '0;
            end else if (r_rd[lane] != '1) begin
                wr_data[lane] = r_rd[lane] + 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (we) begin
                mem[wa] <= wr_data;
            end
            if (i_cmd.accept) begin
                r_rd <= mem[row_of(i_item.block_index, in_vals[g])];
            end
        end

        assign rd_row[g] = r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            for (int ch = 0; ch < NCH; ch++) begin
                for (int c = 0; c < CLASSES; c++) begin
                    r_votes[ch][c] <= '0;
                end
            end
        end else if (i_cmd.update) begin
            for (int ch = 0; ch < NCH; ch++) begin
                for (int c = 0; c < CLASSES; c++) begin
                    if (ch_vote[ch]) begin
                        r_votes[ch][c] <= sat_add(r_votes[ch][c], rd_row[ch][c]);
                    end
                end
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            logic [VOTE_W-1:0] f0;
            logic [VOTE_W-1:0] s0;
            f0 = (r_c == '0) ? '0 : r_first[ch];
            s0 = (r_c == '0) ? '0 : r_second[ch];
            sv[ch]       = r_votes[ch][r_c];
            n_first[ch]  = f0;
            n_second[ch] = s0;
            n_top[ch]    = (r_c == '0) ? '0 : r_top[ch];
            if (sv[ch] > f0) begin
                n_first[ch]  = sv[ch];
                n_second[ch] = f0;
                n_top[ch]    = r_c;
            end else if (sv[ch] > s0) begin
                n_second[ch] = sv[ch];
            end
        end
        fsum = fuse_sum(r_mode, sv[0], sv[1], sv[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
        end else if (i_cmd.scan_step || i_cmd.pscan_step) begin
            r_c <= o_stat.scan_last ? '0 : r_c + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            for (int ch = 0; ch < NCH; ch++) begin
                r_first[ch]  <= n_first[ch];
                r_second[ch] <= n_second[ch];
                r_top[ch]    <= n_top[ch];
            end
            if (r_c == '0 || fsum > r_best) begin
                r_best     <= fsum;
                r_best_idx <= r_c;
            end
        end
        if (i_cmd.pscan_step) begin
            if (r_c == '0 || r_points[r_c] > r_pbest) begin
                r_pbest <= r_points[r_c];
                r_pidx  <= r_c;
            end
        end
    end

    assign bval = r_votes[r_bch][r_ord[i_cmd.bload ? r_bi : r_bj]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bi  <= '0;
            r_bj  <= '0;
            r_bch <= '0;
        end else if (i_cmd.scan_step) begin
            r_bi  <= '0;
            r_bch <= '0;
            for (int k = 0; k < CLASSES; k++) begin
                r_ord[k]    <= CLS_W'(k);
                r_points[k] <= '0;
            end
        end else if (i_cmd.bload) begin
            r_champ     <= r_ord[r_bi];
            r_champ_val <= bval;
            r_bj        <= r_bi + 1'b1;
        end else if (i_cmd.bcmp) begin
            if (bval > r_champ_val) begin
                r_ord[r_bj] <= r_champ;
                r_champ     <= r_ord[r_bj];
                r_champ_val <= bval;
            end
            r_bj <= r_bj + 1'b1;
        end else if (i_cmd.bfin) begin
            r_points[r_champ] <= r_points[r_champ] + PTS_W'(CLASSES - 1) - PTS_W'(r_bi);
            if (o_stat.pass_last) begin
                r_bi  <= '0;
                r_bch <= r_bch + 1'b1;
                for (int k = 0; k < CLASSES; k++) begin
                    r_ord[k] <= CLS_W'(k);
                end
            end else begin
                r_ord[r_bi] <= r_champ;
                r_bi        <= r_bi + 1'b1;
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            lead[ch] = r_first[ch] - r_second[ch];
        end
        peak   = (r_first[2] == '0) ? VOTE_W'(1) : r_first[2];
        lead10 = LEAD10_W'(lead[2]) * LEAD10_W'(10);
        unique case (r_mode)
            MODE_MAJ: begin
                if (r_top[0] == r_top[1] || r_top[0] == r_top[2]) begin
                    fused = r_top[0];
                end else if (r_top[1] == r_top[2]) begin
                    fused = r_top[1];
                end else if (lead[2] >= lead[0] && lead[2] >= lead[1]) begin
                    fused = r_top[2];
                end else if (lead[0] >= lead[1]) begin
                    fused = r_top[0];
                end else begin
                    fused = r_top[1];
                end
            end
            MODE_BORDA: begin
                fused = r_pidx;
            end
            MODE_VGRAD: begin
                fused = (lead10 > LEAD10_W'(peak)) ? r_top[2] : r_best_idx;
            end
            default: begin
                fused = r_best_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_fused <= CLS_OUT_W'(fused);
            r_pcls  <= CLS_OUT_W'(r_top[0]);
            r_hcls  <= CLS_OUT_W'(r_top[1]);
            r_vcls  <= CLS_OUT_W'(r_top[2]);
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.fused_class = r_fused;
    assign o_out.pixel_class = r_pcls;
    assign o_out.hgrad_class = r_hcls;
    assign o_out.vgrad_class = r_vcls;

    assign o_stat.is_clear  = (r_item.command == CMD_CLEAR);
    assign o_stat.is_result = (r_item.command == CMD_CLASSIFY) && r_item.last_block;
    assign o_stat.clr_last  = (r_clr_ptr == ROW_W'(ROWS - 1));
    assign o_stat.scan_last = (r_c == CLS_W'(CLASSES - 1));
    assign o_stat.borda     = (r_mode == MODE_BORDA);
    assign o_stat.cmp_last  = (r_bj == CLS_W'(CLASSES - 1));
    assign o_stat.pass_last = (r_bi == CLS_W'(CLASSES - 2));
    assign o_stat.ch_last   = (r_bch == CH_W'(NCH - 1));
    assign o_stat.out_free  = !r_valid || o_out.ready;

endmodule

>>> hw/rtl/hot_map_vote_classifier.sv
// Channel  Direction  Payload
// i_in     sink       command, block_index, three block codes, class_label, last_block
// o_out    source     fused_class, pixel_class, hgrad_class, vgrad_class
// i_cfg    sink       fusion_mode, always ready
//
// A train or classify beat does one count-row read, then the update.
// A clear beat and reset run a clearing pass over all BLOCKS*BLOCK_VALUES rows (6804).
// A last classify beat adds a class scan, or for Borda a scan plus a selection sort of
// each channel's votes and a second scan, then a result state that loads the output.
// A result waits in the output register; only a second result stalls the block.
module hot_map_vote_classifier import hmvc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hmvc_in_if.sink    i_in,
    hmvc_out_if.source o_out,
    hmvc_cfg_if.sink   i_cfg
);

    t_item    item;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign item.command     = i_in.command;
    assign item.block_index = i_in.block_index;
    assign item.pixel_value = i_in.pixel_value;
    assign item.hgrad_value = i_in.hgrad_value;
    assign item.vgrad_value = i_in.vgrad_value;
    assign item.class_label = i_in.class_label;
    assign item.last_block  = i_in.last_block;

    hmvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hmvc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule

>>> tb/hmvc_checker.sv
module hmvc_checker import hmvc_pkg::*; (
    input  logic i_clk,
    hmvc_in_if   in_ch,
    hmvc_out_if  out_ch,
    hmvc_cfg_if  cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int TAB_LEN = ROWS * CLASSES;
    localparam longint unsigned VOTE_MAX = 64'hFF_FFFF;

    typedef longint unsigned t_tally [CLASSES];

    typedef struct packed {
        logic [CLS_OUT_W-1:0] fused;
        logic [CLS_OUT_W-1:0] px;
        logic [CLS_OUT_W-1:0] hg;
        logic [CLS_OUT_W-1:0] vg;
    } t_verdict;

    logic [COUNT_W-1:0] count_tab [NCH][TAB_LEN];
    t_tally             vote_acc [NCH];
    logic [MODE_W-1:0]  mode;
    t_verdict           verdict_q [$];

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        mode = MODE_ADD;
        for (int ch = 0; ch < NCH; ch++) begin
            for (int i = 0; i < TAB_LEN; i++) count_tab[ch][i] = '0;
            for (int c = 0; c < CLASSES; c++) vote_acc[ch][c] = 0;
        end
    end

    function automatic int top_of(t_tally v);
        int w;
        w = 0;
        for (int c = 1; c < CLASSES; c++) if (v[c] > v[w]) w = c;
        return w;
    endfunction

    function automatic longint unsigned lead_of(t_tally v);
        longint unsigned first, second;
        first = 0;
        second = 0;
        for (int c = 0; c < CLASSES; c++) begin
            if (v[c] > first) begin
                second = first;
                first = v[c];
            end else if (v[c] > second) begin
                second = v[c];
            end
        end
        return first - second;
    endfunction

    function automatic int weighted(longint unsigned wp, longint unsigned wh,
                                    longint unsigned wv);
        t_tally f;
        for (int c = 0; c < CLASSES; c++)
            f[c] = wp * vote_acc[0][c] + wh * vote_acc[1][c] + wv * vote_acc[2][c];
        return top_of(f);
    endfunction

    function automatic int by_majority();
        int p, h, v;
        longint unsigned mp, mh, mv;
        p = top_of(vote_acc[0]);
        h = top_of(vote_acc[1]);
        v = top_of(vote_acc[2]);
        mp = lead_of(vote_acc[0]);
        mh = lead_of(vote_acc[1]);
        mv = lead_of(vote_acc[2]);
        if (p == h || p == v) return p;
        if (h == v) return h;
        if (mv >= mp && mv >= mh) return v;
        if (mp >= mh) return p;
        return h;
    endfunction

    function automatic int by_borda();
        t_tally pts;
        int ord [CLASSES];
        int t;
        for (int c = 0; c < CLASSES; c++) pts[c] = 0;
        for (int ch = 0; ch < NCH; ch++) begin
            for (int c = 0; c < CLASSES; c++) ord[c] = c;
            for (int i = 0; i < CLASSES - 1; i++)
                for (int j = i + 1; j < CLASSES; j++)
                    if (vote_acc[ch][ord[j]] > vote_acc[ch][ord[i]]) begin
                        t = ord[i];
                        ord[i] = ord[j];
                        ord[j] = t;
                    end
            for (int r = 0; r < CLASSES; r++) pts[ord[r]] += CLASSES - 1 - r;
        end
        return top_of(pts);
    endfunction

    function automatic int by_vgrad_first();
        longint unsigned peak;
        t_tally f;
        peak = 1;
        for (int c = 0; c < CLASSES; c++) if (vote_acc[2][c] > peak) peak = vote_acc[2][c];
        if (lead_of(vote_acc[2]) > peak / 10) return top_of(vote_acc[2]);
        for (int c = 0; c < CLASSES; c++) f[c] = 2 * vote_acc[2][c] + vote_acc[0][c];
        return top_of(f);
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    task automatic absorb(t_item it);
        logic [VAL_W-1:0] vals [NCH];
        int idx, base, fused;
        longint unsigned s;
        t_verdict vd;
        vals[0] = it.pixel_value;
        vals[1] = it.hgrad_value;
        vals[2] = it.vgrad_value;
        case (it.command)
            CMD_CLEAR: begin
                for (int ch = 0; ch < NCH; ch++)
                    for (int i = 0; i < TAB_LEN; i++) count_tab[ch][i] = '0;
            end
            CMD_TRAIN: begin
                if (it.block_index < BLOCKS && it.class_label < CLASSES) begin
                    for (int ch = 0; ch < NCH; ch++) begin
                        if (vals[ch] < BLOCK_VALUES) begin
                            idx = (it.block_index * BLOCK_VALUES + vals[ch]) * CLASSES
                                  + it.class_label;
                            if (count_tab[ch][idx] != '1) count_tab[ch][idx]++;
                        end
                    end
                end
            end
            CMD_CLASSIFY: begin
                if (it.block_index < BLOCKS) begin
                    for (int ch = 0; ch < NCH; ch++) begin
                        if (vals[ch] != (ch == 0 ? PIXEL_BG : GRAD_BG)
                            && vals[ch] < BLOCK_VALUES) begin
                            base = (it.block_index * BLOCK_VALUES + vals[ch]) * CLASSES;
                            for (int c = 0; c < CLASSES; c++) begin
                                s = vote_acc[ch][c] + count_tab[ch][base + c];
                                vote_acc[ch][c] = (s > VOTE_MAX) ? VOTE_MAX : s;
                            end
                        end
                    end
                end
                if (it.last_block) begin
                    case (mode)
                        MODE_MAJ:    fused = by_majority();
                        MODE_BORDA:  fused = by_borda();
                        MODE_VGRAD:  fused = by_vgrad_first();
                        MODE_PV:     fused = weighted(1, 0, 1);
                        MODE_WEIGHT: fused = weighted(2, 1, 4);
                        default:     fused = weighted(1, 1, 1);
                    endcase
                    vd.fused = CLS_OUT_W'(fused);
                    vd.px = CLS_OUT_W'(top_of(vote_acc[0]));
                    vd.hg = CLS_OUT_W'(top_of(vote_acc[1]));
                    vd.vg = CLS_OUT_W'(top_of(vote_acc[2]));
                    verdict_q.push_back(vd);
                    for (int ch = 0; ch < NCH; ch++)
                        for (int c = 0; c < CLASSES; c++) vote_acc[ch][c] = 0;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        t_item it;
        if (out_ch.valid && out_ch.ready) begin
            if (verdict_q.size() == 0) begin
                report("unexpected result, fused_class", out_ch.fused_class, 0);
            end else begin
                want = verdict_q.pop_front();
                if (out_ch.fused_class !== want.fused)
                    report("fused_class", out_ch.fused_class, want.fused);
                if (out_ch.pixel_class !== want.px)
                    report("pixel_class", out_ch.pixel_class, want.px);
                if (out_ch.hgrad_class !== want.hg)
                    report("hgrad_class", out_ch.hgrad_class, want.hg);
                if (out_ch.vgrad_class !== want.vg)
                    report("vgrad_class", out_ch.vgrad_class, want.vg);
            end
        end
        if (cfg_ch.valid && cfg_ch.ready) mode = cfg_ch.fusion_mode;
        if (in_ch.valid && in_ch.ready) begin
            it.command = in_ch.command;
            it.block_index = in_ch.block_index;
            it.pixel_value = in_ch.pixel_value;
            it.hgrad_value = in_ch.hgrad_value;
            it.vgrad_value = in_ch.vgrad_value;
            it.class_label = in_ch.class_label;
            it.last_block = in_ch.last_block;
            absorb(it);
        end
        o_pending = verdict_q.size();
    end

endmodule

>>> tb/tb_top.sv
module tb_top;
    import hmvc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam int CLEAR_WAIT = 7000;
    localparam int IDLE_LIMIT = 40000;
    localparam int PHASE_ITEMS = 180;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   hold;
    bit   calm;

    hmvc_in_if  in_ch ();
    hmvc_out_if out_ch ();
    hmvc_cfg_if cfg_ch ();

    hot_map_vote_classifier DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    hmvc_checker u_checker (
        .i_clk        (i_clk),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge i_clk) begin
        if (hold > 0) begin
            hold--;
        end else begin
            out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 2) != 0);
            hold = gap_len();
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic t_item mk(logic [CMD_W-1:0] cmd, int blk, int pv, int hv, int vv,
                                 int lbl, bit last);
        t_item it;
        it.command = cmd;
        it.block_index = BLK_W'(blk);
        it.pixel_value = VAL_W'(pv);
        it.hgrad_value = VAL_W'(hv);
        it.vgrad_value = VAL_W'(vv);
        it.class_label = LBL_W'(lbl);
        it.last_block = last;
        return it;
    endfunction

    function automatic int pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return $urandom_range(27, 31);
        if (r < 20) return ($urandom_range(0, 1) != 0) ? int'(PIXEL_BG) : int'(GRAD_BG);
        return $urandom_range(0, 26);
    endfunction

    function automatic t_item rand_item();
        int k, r, blk, lbl;
        logic [CMD_W-1:0] cmd;
        bit last;
        k = $urandom_range(0, 999);
        if (k < 3) cmd = CMD_CLEAR;
        else if (k < 25) cmd = CMD_UNUSED;
        else if (k < 450) cmd = CMD_TRAIN;
        else cmd = CMD_CLASSIFY;
        last = (cmd == CMD_CLASSIFY) ? ($urandom_range(0, 5) == 0)
                                     : ($urandom_range(0, 9) == 0);
        r = $urandom_range(0, 99);
        if (r < 85) blk = $urandom_range(0, 5);
        else if (r < 95) blk = $urandom_range(0, BLOCKS - 1);
        else blk = $urandom_range(BLOCKS, 255);
        lbl = ($urandom_range(0, 99) < 5) ? $urandom_range(CLASSES, 15)
                                          : $urandom_range(0, CLASSES - 1);
        return mk(cmd, blk, pick_value(), pick_value(), pick_value(), lbl, last);
    endfunction

    task automatic send(t_item it);
        int g;
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.command <= it.command;
        in_ch.block_index <= it.block_index;
        in_ch.pixel_value <= it.pixel_value;
        in_ch.hgrad_value <= it.hgrad_value;
        in_ch.vgrad_value <= it.vgrad_value;
        in_ch.class_label <= it.class_label;
        in_ch.last_block <= it.last_block;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        g = calm ? 0 : gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    task automatic set_mode(logic [MODE_W-1:0] m);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        // A clear beat produces no result and may still be running.
        repeat (CLEAR_WAIT) @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.fusion_mode <= m;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        logic [MODE_W-1:0] modes [10];
        modes = '{MODE_MAJ, MODE_BORDA, MODE_VGRAD, MODE_PV, MODE_WEIGHT,
                  MODE_SPARE_LO, MODE_SPARE_HI, MODE_ADD, MODE_WEIGHT, MODE_BORDA};
        i_rst_n = 1'b0;
        idle_cycles = 0;
        hold = 0;
        calm = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_CLEAR;
        in_ch.block_index = '0;
        in_ch.pixel_value = '0;
        in_ch.hgrad_value = '0;
        in_ch.vgrad_value = '0;
        in_ch.class_label = '0;
        in_ch.last_block = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.fusion_mode = MODE_ADD;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_mode(MODE_ADD);
        send(mk(CMD_TRAIN, 0, 1, 2, 3, 9, 0));
        send(mk(CMD_TRAIN, 0, 1, 2, 3, 0, 1));
        send(mk(CMD_TRAIN, 255, 31, 31, 31, 15, 0));
        send(mk(CMD_TRAIN, 1, 27, 28, 31, 5, 0));
        send(mk(CMD_TRAIN, 1, 26, 26, 26, 3, 0));
        send(mk(CMD_TRAIN, 1, 26, 26, 26, 8, 0));
        send(mk(CMD_TRAIN, 251, 26, 0, 0, 8, 0));
        send(mk(CMD_TRAIN, 1, 0, 13, 13, 4, 0));
        send(mk(CMD_CLASSIFY, 0, 1, 2, 3, 0, 0));
        send(mk(CMD_CLASSIFY, 1, 0, 13, 13, 0, 0));
        send(mk(CMD_CLASSIFY, 1, 26, 26, 26, 15, 1));
        send(mk(CMD_CLASSIFY, 255, 31, 31, 31, 0, 1));
        send(mk(CMD_UNUSED, 0, 1, 2, 3, 9, 1));
        send(mk(CMD_CLASSIFY, 1, 27, 31, 28, 0, 1));
        send(mk(CMD_CLASSIFY, 0, 1, 2, 3, 0, 0));
        send(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 1));
        send(mk(CMD_CLASSIFY, 251, 26, 0, 0, 0, 1));
        send(mk(CMD_CLASSIFY, 0, 1, 2, 3, 0, 1));

        for (int p = 0; p < 10; p++) begin
            set_mode(modes[p]);
            calm = (p % 4 == 3);
            for (int i = 0; i < PHASE_ITEMS; i++) send(rand_item());
        end
        calm = 1'b0;

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (CLEAR_WAIT) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
